/* hdl/lcs_pkg.sv */
// shared types and constants for the longest common subsequence unit
// no dependencies

package lcs_pkg;

   localparam int MAX_LEN_DEFAULT = 32;
   localparam int RESULT_LIMIT    = 32;

   localparam logic [1:0] MODE_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] MODE_APPEND_SECOND = 2'd1;
   localparam logic [1:0] MODE_COMPUTE       = 2'd2;

   localparam logic [1:0] DIR_DIAG = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_LEFT = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       has_symbol;
      logic [5:0] lcs_length;
      logic       truncated;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TB_RD,
      ST_TB_DO,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

endpackage

/* hdl/lcs_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies

module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lcs_core.sv */
// string buffers, score row buffer, direction table and sequencer
// depends on lcs_pkg and lcs_ram

module lcs_core import lcs_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_accept,
   input  req_type  req_data,
   input  logic     out_free,
   output logic     idle,
   output emit_type emit
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int DD = MAX_LEN * MAX_LEN;
   localparam int DW = (DD > 1) ? $clog2(DD) : 1;

   state_type state_ff, state_in;

   logic [LW-1:0] first_len_ff, first_len_in;
   logic [LW-1:0] second_len_ff, second_len_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] m_ff, m_in;
   logic [LW-1:0] n_ff, n_in;
   logic          trunc_ff, trunc_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [DW-1:0] row_base_ff, row_base_in;
   logic [DW-1:0] tb_addr_ff, tb_addr_in;
   logic [LW-1:0] diag_ff, diag_in;
   logic [LW-1:0] left_ff, left_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] k_ff, k_in;
   logic [LW-1:0] idx_ff, idx_in;

   logic          first_we, second_we, row_we, dir_we, seq_we;
   logic          first_re, second_re, row_re, dir_re, seq_re;
   logic [7:0]    first_rdata, second_rdata, seq_rdata;
   logic [LW-1:0] row_rdata;
   logic [1:0]    dir_rdata;
   logic [1:0]    cell_dir;
   logic [LW-1:0] cell_score, up_score;
   logic [LW-1:0] emit_count;
   logic          emit_last;
   logic          is_compute;
   logic          empty_job;

   assign is_compute = req_accept && (req_data.mode == MODE_COMPUTE);
   assign empty_job  = (first_len_ff == '0) || (second_len_ff == '0);

   // cell update
   always_comb begin
      up_score = (i_ff == LW'(1)) ? '0 : row_rdata;
      if (first_rdata == second_rdata) begin
         cell_score = LW'(diag_ff + 1'b1);
         cell_dir   = DIR_DIAG;
      end else if (up_score >= left_ff) begin
         cell_score = up_score;
         cell_dir   = DIR_UP;
      end else begin
         cell_score = left_ff;
         cell_dir   = DIR_LEFT;
      end
   end

   assign emit_count = (len_ff == '0) ? LW'(1) :
                       ((int'(len_ff) > RESULT_LIMIT) ? LW'(RESULT_LIMIT) : len_ff);
   assign emit_last  = ((LW+1)'(idx_ff) + 1'b1) == (LW+1)'(emit_count);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_compute) begin
               state_in = empty_job ? ST_EMIT_WR : ST_ROW_RD;
            end
         end
         ST_ROW_RD:  state_in = ST_FILL_RD;
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            if (j_ff != n_ff) begin
               state_in = ST_FILL_RD;
            end else if (i_ff != m_ff) begin
               state_in = ST_ROW_RD;
            end else begin
               state_in = ST_TB_RD;
            end
         end
         ST_TB_RD: begin
            if ((i_ff == '0) || (j_ff == '0)) begin
               state_in = (len_ff == '0) ? ST_EMIT_WR : ST_EMIT_RD;
            end else begin
               state_in = ST_TB_DO;
            end
         end
         ST_TB_DO:   state_in = ST_TB_RD;
         ST_EMIT_RD: state_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (out_free) begin
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      idle      = (state_ff == ST_IDLE);
      first_we  = idle && req_accept && (req_data.mode == MODE_APPEND_FIRST) &&
                  (first_len_ff < LW'(MAX_LEN));
      second_we = idle && req_accept && (req_data.mode == MODE_APPEND_SECOND) &&
                  (second_len_ff < LW'(MAX_LEN));
      first_re  = (state_ff == ST_ROW_RD) ||
                  ((state_ff == ST_TB_RD) && (i_ff != '0) && (j_ff != '0));
      second_re = (state_ff == ST_FILL_RD);
      row_re    = (state_ff == ST_FILL_RD);
      row_we    = (state_ff == ST_FILL_WR);
      dir_we    = (state_ff == ST_FILL_WR);
      dir_re    = first_re && (state_ff == ST_TB_RD);
      seq_we    = (state_ff == ST_TB_DO) && (dir_rdata == DIR_DIAG) && (k_ff != '0);
      seq_re    = (state_ff == ST_EMIT_RD);

      emit.valid           = (state_ff == ST_EMIT_WR);
      emit.data.has_symbol = (len_ff != '0);
      emit.data.out_symbol = (len_ff != '0) ? seq_rdata : 8'd0;
      emit.data.lcs_length = 6'(len_ff);
      emit.data.truncated  = trunc_ff;
      emit.data.last       = emit_last;
   end

   // datapath
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      ovf_in        = ovf_ff;
      m_in          = m_ff;
      n_in          = n_ff;
      trunc_in      = trunc_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      row_base_in   = row_base_ff;
      tb_addr_in    = tb_addr_ff;
      diag_in       = diag_ff;
      left_in       = left_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.mode)
                  MODE_APPEND_FIRST: begin
                     if (first_len_ff < LW'(MAX_LEN)) begin
                        first_len_in = LW'(first_len_ff + 1'b1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_APPEND_SECOND: begin
                     if (second_len_ff < LW'(MAX_LEN)) begin
                        second_len_in = LW'(second_len_ff + 1'b1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  MODE_COMPUTE: begin
                     m_in          = first_len_ff;
                     n_in          = second_len_ff;
                     trunc_in      = ovf_ff;
                     first_len_in  = '0;
                     second_len_in = '0;
                     ovf_in        = 1'b0;
                     i_in          = LW'(1);
                     j_in          = LW'(1);
                     row_base_in   = '0;
                     diag_in       = '0;
                     left_in       = '0;
                     len_in        = '0;
                     idx_in        = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL_WR: begin
            diag_in = up_score;
            left_in = cell_score;
            if (j_ff != n_ff) begin
               j_in = LW'(j_ff + 1'b1);
            end else if (i_ff != m_ff) begin
               i_in        = LW'(i_ff + 1'b1);
               j_in        = LW'(1);
               row_base_in = row_base_ff + DW'(MAX_LEN);
               diag_in     = '0;
               left_in     = '0;
            end else begin
               len_in     = cell_score;
               k_in       = cell_score;
               tb_addr_in = row_base_ff + DW'(j_ff - 1'b1);
            end
         end
         ST_TB_RD: begin
            idx_in = '0;
         end
         ST_TB_DO: begin
            case (dir_rdata)
               DIR_DIAG: begin
                  if (k_ff != '0) begin
                     k_in = LW'(k_ff - 1'b1);
                  end
                  i_in       = LW'(i_ff - 1'b1);
                  j_in       = LW'(j_ff - 1'b1);
                  tb_addr_in = tb_addr_ff - DW'(MAX_LEN + 1);
               end
               DIR_UP: begin
                  i_in       = LW'(i_ff - 1'b1);
                  tb_addr_in = tb_addr_ff - DW'(MAX_LEN);
               end
               default: begin
                  j_in       = LW'(j_ff - 1'b1);
                  tb_addr_in = tb_addr_ff - DW'(1);
               end
            endcase
         end
         ST_EMIT_WR: begin
            if (out_free && !emit_last) begin
               idx_in = LW'(idx_ff + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      n_ff        <= n_in;
      trunc_ff    <= trunc_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      row_base_ff <= row_base_in;
      tb_addr_ff  <= tb_addr_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      len_ff      <= len_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
   end

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
      .clock   (clock),
      .wr_en   (first_we),
      .wr_addr (IW'(first_len_ff)),
      .wr_data (req_data.symbol),
      .rd_en   (first_re),
      .rd_addr (IW'(i_ff - 1'b1)),
      .rd_data (first_rdata)
   );

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
      .clock   (clock),
      .wr_en   (second_we),
      .wr_addr (IW'(second_len_ff)),
      .wr_data (req_data.symbol),
      .rd_en   (second_re),
      .rd_addr (IW'(j_ff - 1'b1)),
      .rd_data (second_rdata)
   );

   // previous score row, overwritten in place with the current row
   lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (IW'(j_ff - 1'b1)),
      .wr_data (cell_score),
      .rd_en   (row_re),
      .rd_addr (IW'(j_ff - 1'b1)),
      .rd_data (row_rdata)
   );

   lcs_ram #(.WIDTH(2), .DEPTH(DD)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (row_base_ff + DW'(j_ff - 1'b1)),
      .wr_data (cell_dir),
      .rd_en   (dir_re),
      .rd_addr (tb_addr_ff),
      .rd_data (dir_rdata)
   );

   lcs_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_we),
      .wr_addr (IW'(k_ff - 1'b1)),
      .wr_data (first_rdata),
      .rd_en   (seq_re),
      .rd_addr (IW'(idx_ff)),
      .rd_data (seq_rdata)
   );

endmodule

/* hdl/lcs_length_and_traceback_unit.sv */
// operation: an append is taken while idle; a compute fills the table row by row (a row
// start state, then a read state and a write state per cell through the row buffer ram), then
// traces back through the direction table, then reads each result from the sequence ram.
// throughput: one transaction at a time; req_ready is high only while idle.
// reset: synchronous, active high; clears lengths, overflow flag, sequencer and
// rsp_valid. string contents are undefined until written; no clearing pass.
// top level: output register around lcs_core; depends on lcs_pkg, lcs_core

module lcs_length_and_traceback_unit import lcs_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     idle;
   logic     out_free;
   emit_type emit;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   assign req_ready = idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   lcs_core #(.MAX_LEN(MAX_LEN)) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_valid && req_ready),
      .req_data   (req_data),
      .out_free   (out_free),
      .idle       (idle),
      .emit       (emit)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit.data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/lcs_checker.sv */
// port level checks for the longest common subsequence unit, bound to the top
// depends on lcs_pkg and lcs_length_and_traceback_unit

module lcs_checker import lcs_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_symbol |->
         rsp_data.last && (rsp_data.lcs_length == 6'd0) && (rsp_data.out_symbol == 8'd0))
      else $error("empty result not well formed");

   a_compute_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.mode == MODE_COMPUTE) |=> !req_ready)
      else $error("ready right after compute transaction");

   a_busy_until_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> !req_ready)
      else $error("ready while results pending");

endmodule

bind lcs_length_and_traceback_unit lcs_checker u_lcs_checker (.*);
